/* rtl/core/masked_rgb_histogram_match_defines.svh */
// assertion macros used by the checker
// no dependencies
`ifndef MASKED_RGB_HISTOGRAM_MATCH_DEFINES_SVH
`define MASKED_RGB_HISTOGRAM_MATCH_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MRHM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrhm check failed");

// antecedent implies consequent in the next cycle
`define MRHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrhm check failed");

`endif

/* rtl/core/mrhm_pkg.sv */
// shared constants for the masked rgb histogram matcher
// no dependencies
package mrhm_pkg;
   localparam int NUM_PIX_CH = 3;
   localparam int CH_IDX_BITS = 2;
   localparam int LEVEL_BITS = 8;

   localparam logic [2:0] OP_CNT_ADJ = 3'd0;
   localparam logic [2:0] OP_CNT_REF = 3'd1;
   localparam logic [2:0] OP_BUILD   = 3'd2;
   localparam logic [2:0] OP_MAP     = 3'd3;
   localparam logic [2:0] OP_CLEAR   = 3'd4;

   typedef logic [NUM_PIX_CH-1:0][LEVEL_BITS-1:0] pix_type;
endpackage

/* rtl/core/mrhm_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module mrhm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* rtl/core/masked_rgb_histogram_match.sv */
// Masked RGB histogram matcher. Each request carries an opcode and one pixel.
// Count requests (adjust or reference) run bin read, saturating write back
// (skipped when the mask bit is low) and result load. A map request reads the
// table rams. A clear writes zero to all 256 bins, and the same clearing pass
// runs after reset before the first request is taken. A build runs channel
// after channel: a min pass, a sum pass, then either an identity fill or a
// match walk of at most 511 steps, each step one bin read plus a digit-serial
// cross-multiply compare. Flat channels get the identity table and their
// flat_channels bit set. One result per request.
// depends on mrhm_pkg and mrhm_ram
module masked_rgb_histogram_match
   import mrhm_pkg::*;
#(
   parameter int COUNT_BITS = 24,
   parameter int CHANNELS = 3
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   input  logic       req_mask_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out,
   output logic [2:0] rsp_flat_channels
);
   localparam int ACT = (CHANNELS < NUM_PIX_CH) ? CHANNELS : NUM_PIX_CH;
   localparam int CW = COUNT_BITS;
   localparam int SW = CW + 8;
   localparam int ND = (SW + 7) / 8;
   localparam int MW = ND * 8;
   localparam int PW = SW + MW;
   localparam int DCW = $clog2(ND + 1);
   localparam logic [CW-1:0] CMAX = '1;

   localparam logic [3:0] ST_CLR   = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_CNT   = 4'd2;
   localparam logic [3:0] ST_MAP   = 4'd3;
   localparam logic [3:0] ST_OUT   = 4'd4;
   localparam logic [3:0] ST_BMIN  = 4'd5;
   localparam logic [3:0] ST_BSUM  = 4'd6;
   localparam logic [3:0] ST_BCHK  = 4'd7;
   localparam logic [3:0] ST_BID   = 4'd8;
   localparam logic [3:0] ST_BCMP  = 4'd9;
   localparam logic [3:0] ST_BDEC  = 4'd10;
   localparam logic [3:0] ST_BADDA = 4'd11;
   localparam logic [3:0] ST_BADDR = 4'd12;
   localparam logic [3:0] ST_BNEXT = 4'd13;

   logic [3:0] st_ff, st_in;
   logic [8:0] cnt_ff, cnt_in;
   logic vld_ff, vld_in;
   logic [7:0] adr_ff, adr_in;
   logic [2:0] op_ff, op_in;
   pix_type pix_ff, pix_in, req_pix, map_pix;
   logic [CH_IDX_BITS-1:0] bch_ff, bch_in;
   logic [CW-1:0] mn1_ff, mn1_in, mn2_ff, mn2_in;
   logic [SW-1:0] tot1_ff, tot1_in, tot2_ff, tot2_in;
   logic [SW-1:0] t1_ff, t1_in, t2_ff, t2_in;
   logic [7:0] j_ff, j_in, k_ff, k_in;
   logic [PW-1:0] acca_ff, acca_in, accb_ff, accb_in;
   logic [MW-1:0] sha_ff, sha_in, shb_ff, shb_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [2:0] flat_ff, flat_in;
   logic clrack_ff, clrack_in;
   logic res_kind_ff, res_kind_in;
   pix_type res_rgb_ff, res_rgb_in;
   logic [SW+7:0] prod_a, prod_b;
   logic mul_load, take, out_load;
   logic [7:0] bld_addr;
   logic [CW-1:0] sel_adj, sel_ref;

   logic [CW-1:0] adj_rd [NUM_PIX_CH];
   logic [CW-1:0] ref_rd [NUM_PIX_CH];
   logic [7:0] map_rd [NUM_PIX_CH];

   assign req_pix[0] = req_red_in;
   assign req_pix[1] = req_green_in;
   assign req_pix[2] = req_blue_in;
   assign req_ready = (st_ff == ST_IDLE);
   assign take = (acca_ff >= accb_ff) || (k_ff == 8'hff);
   assign sel_adj = adj_rd[bch_ff];
   assign sel_ref = ref_rd[bch_ff];
   assign prod_a = t2_ff * sha_ff[MW-1 -: 8];
   assign prod_b = t1_ff * shb_ff[MW-1 -: 8];
   assign bld_addr = (st_ff == ST_BDEC) ? (take ? j_ff + 8'd1 : k_ff + 8'd1)
                                        : cnt_ff[7:0];

   for (genvar c = 0; c < NUM_PIX_CH; c++) begin : g_ch
      if (c < ACT) begin : g_act
         logic [7:0] h_raddr;
         logic [7:0] h_waddr;
         logic adj_we, ref_we, map_we;
         logic [CW-1:0] adj_wd, ref_wd;
         logic [7:0] map_wa, map_wd;

         assign h_raddr = (st_ff == ST_IDLE) ? req_pix[c] : bld_addr;
         assign h_waddr = (st_ff == ST_CLR) ? cnt_ff[7:0] : pix_ff[c];
         assign adj_we = (st_ff == ST_CLR) || (st_ff == ST_CNT && op_ff == OP_CNT_ADJ);
         assign ref_we = (st_ff == ST_CLR) || (st_ff == ST_CNT && op_ff == OP_CNT_REF);
         assign adj_wd = (st_ff == ST_CLR) ? '0
                       : ((adj_rd[c] < CMAX) ? adj_rd[c] + CW'(1) : adj_rd[c]);
         assign ref_wd = (st_ff == ST_CLR) ? '0
                       : ((ref_rd[c] < CMAX) ? ref_rd[c] + CW'(1) : ref_rd[c]);
         assign map_we = (bch_ff == CH_IDX_BITS'(c))
                       && ((st_ff == ST_BID) || (st_ff == ST_BDEC && take));
         assign map_wa = (st_ff == ST_BID) ? cnt_ff[7:0] : j_ff;
         assign map_wd = (st_ff == ST_BID) ? cnt_ff[7:0] : k_ff;

         mrhm_ram #(.WIDTH(CW), .DEPTH(256)) u_adj (
            .clock(clock), .wr_en(adj_we), .wr_addr(h_waddr), .wr_data(adj_wd),
            .rd_addr(h_raddr), .rd_data(adj_rd[c])
         );
         mrhm_ram #(.WIDTH(CW), .DEPTH(256)) u_ref (
            .clock(clock), .wr_en(ref_we), .wr_addr(h_waddr), .wr_data(ref_wd),
            .rd_addr(h_raddr), .rd_data(ref_rd[c])
         );
         mrhm_ram #(.WIDTH(8), .DEPTH(256)) u_map (
            .clock(clock), .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
            .rd_addr(req_pix[c]), .rd_data(map_rd[c])
         );
         assign map_pix[c] = map_rd[c];
      end else begin : g_idle
         assign adj_rd[c] = '0;
         assign ref_rd[c] = '0;
         assign map_rd[c] = pix_ff[c];
         assign map_pix[c] = map_rd[c];
      end
   end

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      vld_in = vld_ff;
      adr_in = adr_ff;
      op_in = op_ff;
      pix_in = pix_ff;
      bch_in = bch_ff;
      mn1_in = mn1_ff;
      mn2_in = mn2_ff;
      tot1_in = tot1_ff;
      tot2_in = tot2_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      j_in = j_ff;
      k_in = k_ff;
      acca_in = acca_ff;
      accb_in = accb_ff;
      sha_in = sha_ff;
      shb_in = shb_ff;
      dcnt_in = dcnt_ff;
      flat_in = flat_ff;
      clrack_in = clrack_ff;
      res_kind_in = res_kind_ff;
      res_rgb_in = res_rgb_ff;
      mul_load = 1'b0;
      case (st_ff)
         ST_CLR: begin
            cnt_in = cnt_ff + 9'd1;
            if (cnt_ff[7:0] == 8'hff) begin
               cnt_in = '0;
               st_in = clrack_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode;
               pix_in = req_pix;
               res_kind_in = 1'b0;
               res_rgb_in = '0;
               cnt_in = '0;
               vld_in = 1'b0;
               case (req_opcode)
                  OP_CNT_ADJ, OP_CNT_REF: st_in = req_mask_in ? ST_CNT : ST_OUT;
                  OP_BUILD: begin
                     bch_in = '0;
                     st_in = ST_BMIN;
                  end
                  OP_MAP: st_in = ST_MAP;
                  OP_CLEAR: begin
                     clrack_in = 1'b1;
                     st_in = ST_CLR;
                  end
                  default: st_in = ST_OUT;
               endcase
            end
         end
         ST_CNT: st_in = ST_OUT;
         ST_MAP: begin
            res_kind_in = 1'b1;
            res_rgb_in = map_pix;
            st_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid || rsp_ready) begin
               st_in = ST_IDLE;
            end
         end
         ST_BMIN, ST_BSUM: begin
            if (!cnt_ff[8]) begin
               cnt_in = cnt_ff + 9'd1;
            end
            vld_in = !cnt_ff[8];
            adr_in = cnt_ff[7:0];
            if (vld_ff) begin
               if (st_ff == ST_BMIN) begin
                  if (adr_ff == 8'd0 || sel_adj < mn1_ff) begin
                     mn1_in = sel_adj;
                  end
                  if (adr_ff == 8'd0 || sel_ref < mn2_ff) begin
                     mn2_in = sel_ref;
                  end
               end else if (adr_ff != 8'd0) begin
                  tot1_in = tot1_ff + SW'(sel_adj - mn1_ff);
                  tot2_in = tot2_ff + SW'(sel_ref - mn2_ff);
               end
            end
            if (cnt_ff[8] && !vld_ff) begin
               cnt_in = '0;
               tot1_in = '0;
               tot2_in = '0;
               st_in = (st_ff == ST_BMIN) ? ST_BSUM : ST_BCHK;
               if (st_ff == ST_BSUM) begin
                  tot1_in = tot1_ff;
                  tot2_in = tot2_ff;
               end
            end
         end
         ST_BCHK: begin
            cnt_in = '0;
            if (tot1_ff == '0 || tot2_ff == '0) begin
               flat_in[bch_ff] = 1'b1;
               st_in = ST_BID;
            end else begin
               flat_in[bch_ff] = 1'b0;
               j_in = '0;
               k_in = '0;
               t1_in = '0;
               t2_in = '0;
               mul_load = 1'b1;
               st_in = ST_BCMP;
            end
         end
         ST_BID: begin
            cnt_in = cnt_ff + 9'd1;
            if (cnt_ff[7:0] == 8'hff) begin
               st_in = ST_BNEXT;
            end
         end
         ST_BCMP: begin
            acca_in = {acca_ff[PW-9:0], 8'h00} + PW'(prod_a);
            accb_in = {accb_ff[PW-9:0], 8'h00} + PW'(prod_b);
            sha_in = {sha_ff[MW-9:0], 8'h00};
            shb_in = {shb_ff[MW-9:0], 8'h00};
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(ND - 1)) begin
               st_in = ST_BDEC;
            end
         end
         ST_BDEC: begin
            if (take) begin
               if (j_ff == 8'hff) begin
                  st_in = ST_BNEXT;
               end else begin
                  j_in = j_ff + 8'd1;
                  st_in = ST_BADDA;
               end
            end else begin
               k_in = k_ff + 8'd1;
               st_in = ST_BADDR;
            end
         end
         ST_BADDA: begin
            t1_in = t1_ff + SW'(sel_adj - mn1_ff);
            mul_load = 1'b1;
            st_in = ST_BCMP;
         end
         ST_BADDR: begin
            t2_in = t2_ff + SW'(sel_ref - mn2_ff);
            mul_load = 1'b1;
            st_in = ST_BCMP;
         end
         ST_BNEXT: begin
            if (bch_ff == CH_IDX_BITS'(ACT - 1)) begin
               st_in = ST_OUT;
            end else begin
               bch_in = bch_ff + CH_IDX_BITS'(1);
               cnt_in = '0;
               vld_in = 1'b0;
               st_in = ST_BMIN;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (mul_load) begin
         acca_in = '0;
         accb_in = '0;
         sha_in = MW'(tot1_ff);
         shb_in = MW'(tot2_ff);
         dcnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLR;
         cnt_ff <= '0;
         vld_ff <= 1'b0;
         bch_ff <= '0;
         dcnt_ff <= '0;
         flat_ff <= '0;
         clrack_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
         bch_ff <= bch_in;
         dcnt_ff <= dcnt_in;
         flat_ff <= flat_in;
         clrack_ff <= (st_ff == ST_OUT) ? 1'b0 : clrack_in;
      end
      adr_ff <= adr_in;
      op_ff <= op_in;
      pix_ff <= pix_in;
      mn1_ff <= mn1_in;
      mn2_ff <= mn2_in;
      tot1_ff <= tot1_in;
      tot2_ff <= tot2_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      j_ff <= j_in;
      k_ff <= k_in;
      acca_ff <= acca_in;
      accb_ff <= accb_in;
      sha_ff <= sha_in;
      shb_ff <= shb_in;
      res_kind_ff <= res_kind_in;
      res_rgb_ff <= res_rgb_in;
   end

   assign out_load = (st_ff == ST_OUT) && (!rsp_valid || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
      if (out_load) begin
         rsp_result_kind <= res_kind_ff;
         rsp_red_out <= res_rgb_ff[0];
         rsp_green_out <= res_rgb_ff[1];
         rsp_blue_out <= res_rgb_ff[2];
         rsp_flat_channels <= flat_ff;
      end
   end
endmodule

/* rtl/core/mrhm_checker.sv */
// port-level checks for the masked rgb histogram matcher, bound to the top level
// depends on masked_rgb_histogram_match_defines.svh
`include "masked_rgb_histogram_match_defines.svh"
module mrhm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_result_kind,
   input logic [7:0] rsp_red_out,
   input logic [7:0] rsp_green_out,
   input logic [7:0] rsp_blue_out,
   input logic [2:0] rsp_flat_channels
);
   `MRHM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_result_kind, rsp_red_out, rsp_green_out, rsp_blue_out, rsp_flat_channels}))
   `MRHM_ASSERT_NOW(a_ack_zero, clock, reset, rsp_valid && !rsp_result_kind, rsp_red_out == 8'd0 && rsp_green_out == 8'd0 && rsp_blue_out == 8'd0)
   `MRHM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind masked_rgb_histogram_match mrhm_checker u_mrhm_checker (.*);

/* tb/sv/tb.sv */
// self-checking testbench for masked_rgb_histogram_match: predicts every response
// from its own histogram and table state; depends on mrhm_pkg and the block rtl
`timescale 1ns / 100ps
module tb;
   import mrhm_pkg::*;

   localparam int IDLE_LIMIT = 40000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [2:0] opcode;
      logic [7:0] red, green, blue;
      logic       mask;
   } pixel_request_type;

   typedef struct {
      logic       kind;
      logic [7:0] red, green, blue;
      logic [2:0] flat;
   } match_response_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_mask_in = 0, rsp_ready = 0;
   logic [2:0] req_opcode = OP_CNT_ADJ;
   logic [7:0] req_red_in = 0, req_green_in = 0, req_blue_in = 0;
   logic req_ready, rsp_valid, rsp_result_kind;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic [2:0] rsp_flat_channels;

   masked_rgb_histogram_match uut (.*);

   pixel_request_type  pending_requests[$];
   match_response_type expected_responses[$];

   bit [23:0] adj_bins[3][256];
   bit [23:0] ref_bins[3][256];
   bit [7:0]  level_map[3][256];
   bit [2:0]  flat_mask;

   int idle_mode = 0;
   bit hold_req = 0, hold_done = 0;
   int hold_cnt = 0;
   int errors = 0, responses_seen = 0, builds_sent = 0, maps_sent = 0, idle_cycles = 0;
   bit req_fire = 0;

   function automatic void cumulative_sum(input bit use_ref, input int c,
                                          output longint unsigned t[256]);
      longint unsigned mn, v;
      mn = use_ref ? ref_bins[c][0] : adj_bins[c][0];
      for (int i = 1; i < 256; i++) begin
         v = use_ref ? ref_bins[c][i] : adj_bins[c][i];
         if (v < mn) mn = v;
      end
      t[0] = 0;
      for (int i = 1; i < 256; i++) begin
         v = use_ref ? ref_bins[c][i] : adj_bins[c][i];
         t[i] = t[i-1] + (v - mn);
      end
   endfunction

   function automatic void build_level_maps();
      longint unsigned t1[256], t2[256];
      logic [127:0] lhs, rhs;
      int k, last;
      for (int c = 0; c < 3; c++) begin
         cumulative_sum(0, c, t1);
         cumulative_sum(1, c, t2);
         if (t1[255] == 0 || t2[255] == 0) begin
            for (int j = 0; j < 256; j++) level_map[c][j] = j[7:0];
            flat_mask[c] = 1;
         end else begin
            flat_mask[c] = 0;
            last = 0;
            for (int j = 0; j < 256; j++) begin
               for (k = last; k < 255; k++) begin
                  lhs = 128'(t2[k]) * 128'(t1[255]);
                  rhs = 128'(t1[j]) * 128'(t2[255]);
                  if (lhs >= rhs) break;
               end
               level_map[c][j] = k[7:0];
               last = k;
            end
         end
      end
   endfunction

   function automatic match_response_type predict_response(pixel_request_type r);
      match_response_type e;
      logic [7:0] px[3];
      px = '{r.red, r.green, r.blue};
      e = '{kind: 0, red: 0, green: 0, blue: 0, flat: 0};
      case (r.opcode)
         OP_CNT_ADJ, OP_CNT_REF: begin
            if (r.mask)
               for (int c = 0; c < 3; c++)
                  if (r.opcode == OP_CNT_ADJ) begin
                     if (adj_bins[c][px[c]] != 24'hffffff) adj_bins[c][px[c]]++;
                  end else begin
                     if (ref_bins[c][px[c]] != 24'hffffff) ref_bins[c][px[c]]++;
                  end
         end
         OP_BUILD: build_level_maps();
         OP_MAP: begin
            e.kind = 1;
            e.red = level_map[0][r.red];
            e.green = level_map[1][r.green];
            e.blue = level_map[2][r.blue];
         end
         OP_CLEAR: begin
            adj_bins = '{default: '{default: 0}};
            ref_bins = '{default: '{default: 0}};
         end
         default: ;
      endcase
      e.flat = flat_mask;
      return e;
   endfunction

   task automatic push_request(logic [2:0] op, logic [7:0] r, logic [7:0] g,
                               logic [7:0] b, logic m);
      pixel_request_type item;
      item = '{op, r, g, b, m};
      pending_requests.insert(pending_requests.size(), item);
      if (op == OP_BUILD) builds_sent++;
      if (op == OP_MAP) maps_sent++;
   endtask

   function automatic logic [7:0] pick_level(int style, logic [7:0] base);
      case (style)
         0: return 8'($urandom_range(255));
         1: return 8'(base + $urandom_range(7));
         default: return base;
      endcase
   endfunction

   // optionally clear, count both images with stray opcodes mixed in, build, then map a handful of pixels
   task automatic random_sequence();
      int n_adj, n_ref, n_map, style;
      logic [7:0] base;
      if ($urandom_range(3) != 0)
         push_request(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      for (int img = 0; img < 2; img++) begin
         n_adj = $urandom_range(12);
         style = $urandom_range(2);
         base = 8'($urandom);
         for (int i = 0; i < n_adj; i++) begin
            push_request(img == 0 ? OP_CNT_ADJ : OP_CNT_REF, pick_level(style, base),
                         pick_level(style, base + 8'd40), pick_level(style, base + 8'd90),
                         $urandom_range(9) != 0);
            if ($urandom_range(19) == 0)
               push_request(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom),
                            8'($urandom), 1'($urandom));
         end
      end
      push_request(OP_BUILD, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      n_map = $urandom_range(4, 14);
      for (int i = 0; i < n_map; i++)
         push_request(OP_MAP, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic drain();
      wait (pending_requests.size() == 0 && expected_responses.size() == 0 && !req_valid);
      @(posedge clock);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("masked_rgb_histogram_match: mismatch");
            $finish;
         end
      end
      if (req_valid && req_ready)
         expected_responses.insert(expected_responses.size(),
                                   predict_response('{req_opcode, req_red_in,
                                   req_green_in, req_blue_in, req_mask_in}));
      if (rsp_valid && rsp_ready) begin
         match_response_type e;
         responses_seen++;
         if (expected_responses.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            e = expected_responses.pop_front();
            if (e.kind !== rsp_result_kind || e.red !== rsp_red_out
                || e.green !== rsp_green_out || e.blue !== rsp_blue_out
                || e.flat !== rsp_flat_channels) begin
               errors++;
               if (errors <= 10)
                  $display("response %0d: expected %0d %h %h %h %b, got %0d %h %h %h %b",
                           responses_seen, e.kind, e.red, e.green, e.blue, e.flat,
                           rsp_result_kind, rsp_red_out, rsp_green_out, rsp_blue_out,
                           rsp_flat_channels);
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_fire) begin
         if (pending_requests.size() > 0 &&
             !((idle_mode == 1 && $urandom_range(99) < 57) ||
               (idle_mode == 3 && $urandom_range(99) < 28))) begin
            pixel_request_type r;
            r = pending_requests.pop_front();
            req_opcode <= r.opcode;
            req_red_in <= r.red;
            req_green_in <= r.green;
            req_blue_in <= r.blue;
            req_mask_in <= r.mask;
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // response side
   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 0;
      end else if (hold_req && !hold_done) begin
         hold_cnt <= HOLD_CYCLES;
         hold_done <= 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= !((idle_mode == 2 && $urandom_range(99) < 57) ||
                        (idle_mode == 3 && $urandom_range(99) < 28));
      end
   end

   initial begin
      wait (!reset);
      // extremes, flat channels, opcode noise
      push_request(OP_BUILD, 0, 0, 0, 0);
      push_request(OP_MAP, 8'hff, 8'h00, 8'h5a, 1);
      push_request(OP_CNT_ADJ, 8'h00, 8'h00, 8'hff, 1);
      push_request(OP_CNT_ADJ, 8'hff, 8'h00, 8'h00, 1);
      push_request(OP_CNT_ADJ, 8'h80, 8'h00, 8'h7f, 0);
      push_request(OP_CNT_REF, 8'h01, 8'h00, 8'hfe, 1);
      push_request(OP_CNT_REF, 8'hfe, 8'h00, 8'h10, 1);
      push_request(OP_CNT_REF, 8'h55, 8'haa, 8'h33, 0);
      push_request(3'd5, 8'hff, 8'hff, 8'hff, 1);
      push_request(3'd6, 8'h00, 8'h00, 8'h00, 0);
      push_request(3'd7, 8'haa, 8'h55, 8'hcc, 1);
      push_request(OP_BUILD, 0, 0, 0, 0);
      push_request(OP_MAP, 8'h00, 8'hff, 8'h00, 0);
      push_request(OP_MAP, 8'hff, 8'h80, 8'hff, 1);
      push_request(OP_MAP, 8'h80, 8'h01, 8'h7f, 0);
      push_request(OP_CLEAR, 0, 0, 0, 0);
      push_request(OP_MAP, 8'h10, 8'h20, 8'h30, 0);
      push_request(OP_BUILD, 0, 0, 0, 0);
      push_request(OP_MAP, 8'hc3, 8'h3c, 8'h99, 0);
      drain();
      for (int mode = 0; mode < 4; mode++) begin
         idle_mode = mode;
         if (mode == 0) hold_req = 1;
         while (pending_requests.size() < 195) random_sequence();
         drain();
         for (int i = 0; i < 6; i++) @(posedge clock);
      end
      idle_mode = 0;
      repeat (300) @(posedge clock);
      $display("covered %0d builds and %0d pixel maps, %0d responses checked",
               builds_sent, maps_sent, responses_seen);
      $display("all four idling phases plus one long response hold-off");
      if (errors == 0 && expected_responses.size() == 0)
         $display("masked_rgb_histogram_match: match");
      else
         $display("masked_rgb_histogram_match: mismatch");
      $finish;
   end
endmodule
